### rtl/spcc_pkg.sv
// shared types, match constants and helper functions of the ssid confidence classifier
package spcc_pkg;

	// case folding: A-Z move up by this offset
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	// lowered needles, newest byte in the low bits of the window
	localparam logic [63:0] PAT_FLOCK     = 64'h0000_0066_6C6F_636B;
	localparam logic [63:0] MASK_FLOCK    = 64'h0000_00FF_FFFF_FFFF;
	localparam logic [63:0] PAT_FLCK      = 64'h0000_0000_666C_636B;
	localparam logic [63:0] MASK_FLCK     = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] PAT_TEST_TAIL = 64'h6573_745F_666C_636B;
	localparam logic [7:0]  PAT_TEST_HEAD = 8'h74;

	// anchored rule: six prefix bytes then six hex digits
	localparam logic [3:0] ANCHOR_PREFIX_LEN = 4'd6;
	localparam logic [3:0] ANCHOR_NAME_LEN   = 4'd12;
	localparam logic [3:0] POSITION_MAX      = 4'd15;

	// sticky flag bit positions
	localparam int FLAG_TEST  = 0;
	localparam int FLAG_FLOCK = 1;
	localparam int FLAG_FLCK  = 2;

	typedef enum logic [1:0] {
		CONF_NONE      = 2'd0,
		CONF_LIKELY    = 2'd1,
		CONF_CONFIRMED = 2'd2
	} spcc_conf_t;

	typedef enum logic [2:0] {
		RULE_NONE     = 3'd0,
		RULE_ANCHORED = 3'd1,
		RULE_TEST     = 3'd2,
		RULE_FLOCK    = 3'd3,
		RULE_FLCK     = 3'd4
	} spcc_rule_t;

	// per-name scan state
	typedef struct packed {
		logic [63:0] window;
		logic [3:0]  position;
		logic        anchored;
		logic [2:0]  found;
		logic        terminated;
	} spcc_state_t;

	// one classification result
	typedef struct packed {
		spcc_rule_t rule;
		spcc_conf_t conf;
	} spcc_result_t;

	localparam spcc_state_t STATE_RESET = '{
		window:     64'd0,
		position:   4'd0,
		anchored:   1'b1,
		found:      3'd0,
		terminated: 1'b0
	};

	// byte of the anchored prefix at a given position
	function automatic logic [7:0] anchor_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h66;
			3'd1:    b = 8'h6C;
			3'd2:    b = 8'h6F;
			3'd3:    b = 8'h63;
			3'd4:    b = 8'h6B;
			3'd5:    b = 8'h2D;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// lowered hex digit test
	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66));
	endfunction

endpackage

### rtl/ssid_pattern_confidence_classifier_core.sv
// top level of the ssid confidence classifier
// Takes a network name one byte per beat (tlast on the final byte) and gives one result beat
// per name: confidence and the rule that fired. One byte is taken per cycle unless stalled;
// a byte is held in the input register, matched against the scan state and, on the last byte,
// its result is registered in the output register, where it waits until it is taken.
// The rate is set by the combinational window compare and flag update; the only stall is a
// last byte arriving while an untaken result still holds the output register.
module ssid_pattern_confidence_classifier_core import spcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] char_code
	input  logic       s_tlast,  // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [1:0] confidence, [4:2] matched_rule, [7:5] zero
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	logic         advance;
	spcc_state_t  state_q;
	spcc_state_t  state_nxt;
	spcc_result_t result;
	logic         out_valid_q;
	spcc_result_t out_data_q;

	// a byte moves on unless it ends a name while the result register is still full
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	spcc_byte_matcher u_matcher (
		.state_cur (state_q),
		.char_code (char_s1),
		.last_byte (last_s1),
		.state_nxt (state_nxt),
		.result    (result)
	);

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_data_q.rule, out_data_q.conf};

	// no result means no rule and the other way round
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_data_q.conf == CONF_NONE) == (out_data_q.rule == RULE_NONE)))
		else $error("confidence and rule disagree");

	// confirmed only from the anchored or test rule
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_data_q.conf == CONF_CONFIRMED)) |->
		((out_data_q.rule == RULE_ANCHORED) || (out_data_q.rule == RULE_TEST)))
		else $error("confirmed result with a weak rule");

	// the scan state restarts after a name ends
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=>
		((state_q.position == 4'd0) && state_q.anchored && (state_q.found == 3'd0)
		&& !state_q.terminated))
		else $error("scan state not cleared after last byte");

	// a terminated name takes no further bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.terminated && !(advance && last_s1)) |=>
		($stable(state_q.window) && $stable(state_q.position) && $stable(state_q.found)))
		else $error("byte taken after terminator");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(advance && last_s1))
		else $error("result overwritten while stalled");

endmodule

### rtl/spcc_byte_matcher.sv
// next-state and result logic for one name byte
module spcc_byte_matcher import spcc_pkg::*; (
	input  spcc_state_t  state_cur,
	input  logic [7:0]   char_code,
	input  logic         last_byte,
	output spcc_state_t  state_nxt,
	output spcc_result_t result
);

	logic [7:0]  lowered;
	logic [63:0] win_new;
	spcc_state_t upd;

	// fold upper case letters only
	always_comb begin
		if (char_code inside {[8'h41:8'h5A]}) begin
			lowered = char_code + CASE_OFFSET;
		end else begin
			lowered = char_code;
		end
	end

	assign win_new = {state_cur.window[55:0], lowered};

	// take the byte into window, anchor check, flags and position; a zero byte ends the scan
	always_comb begin
		upd = state_cur;
		if (!state_cur.terminated) begin
			if (char_code == 8'd0) begin
				upd.terminated = 1'b1;
			end else begin
				upd.window = win_new;
				if (state_cur.position < ANCHOR_PREFIX_LEN) begin
					if (lowered != anchor_byte(state_cur.position[2:0])) begin
						upd.anchored = 1'b0;
					end
				end else if (state_cur.position < ANCHOR_NAME_LEN) begin
					if (!is_hex(lowered)) begin
						upd.anchored = 1'b0;
					end
				end else begin
					upd.anchored = 1'b0;
				end
				if ((win_new == PAT_TEST_TAIL) && (state_cur.window[63:56] == PAT_TEST_HEAD)) begin
					upd.found[FLAG_TEST] = 1'b1;
				end
				if ((win_new & MASK_FLOCK) == PAT_FLOCK) begin
					upd.found[FLAG_FLOCK] = 1'b1;
				end
				if ((win_new & MASK_FLCK) == PAT_FLCK) begin
					upd.found[FLAG_FLCK] = 1'b1;
				end
				if (state_cur.position != POSITION_MAX) begin
					upd.position = state_cur.position + 4'd1;
				end
			end
		end
	end

	// rule priority on the updated state
	always_comb begin
		result.conf = CONF_NONE;
		result.rule = RULE_NONE;
		if (upd.position != 4'd0) begin
			if (upd.anchored && (upd.position == ANCHOR_NAME_LEN)) begin
				result.conf = CONF_CONFIRMED;
				result.rule = RULE_ANCHORED;
			end else if (upd.found[FLAG_TEST]) begin
				result.conf = CONF_CONFIRMED;
				result.rule = RULE_TEST;
			end else if (upd.found[FLAG_FLOCK]) begin
				result.conf = CONF_LIKELY;
				result.rule = RULE_FLOCK;
			end else if (upd.found[FLAG_FLCK]) begin
				result.conf = CONF_LIKELY;
				result.rule = RULE_FLCK;
			end
		end
	end

	// the last beat of a name restarts the scan
	assign state_nxt = last_byte ? STATE_RESET : upd;

endmodule
